FILE: hdl/bps_pkg.sv
// bps_pkg.sv: shared types, constants and saturation helpers for the particle step block
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

	localparam int BOX_WIDTH  = 900;
	localparam int BOX_HEIGHT = 600;

	localparam int POS_W   = 21;
	localparam int VEL_W   = 24;
	localparam int ACC_W   = 24;
	localparam int REST_W  = 17;
	localparam int RAD_W   = 20;
	localparam int DT_W    = 16;
	localparam int HIT_W   = 4;
	localparam int SUM_W   = 28;
	localparam int SHP_W   = 27;
	localparam int CHK_W   = 23;
	localparam int PADDR_W = 5;

	localparam logic signed [CHK_W-1:0] SIZE_X = CHK_W'(BOX_WIDTH * 256);
	localparam logic signed [CHK_W-1:0] SIZE_Y = CHK_W'(BOX_HEIGHT * 256);

	// register indexes on the configuration port
	localparam logic [2:0] REG_ACCEL_X     = 3'd0;
	localparam logic [2:0] REG_ACCEL_Y     = 3'd1;
	localparam logic [2:0] REG_RESTITUTION = 3'd2;
	localparam logic [2:0] REG_RADIUS      = 3'd3;
	localparam logic [2:0] REG_START_X     = 3'd4;
	localparam logic [2:0] REG_START_Y     = 3'd5;
	localparam logic [2:0] REG_START_VX    = 3'd6;
	localparam logic [2:0] REG_START_VY    = 3'd7;

	localparam logic signed [ACC_W-1:0] RST_ACCEL_X     = 24'sd0;
	localparam logic signed [ACC_W-1:0] RST_ACCEL_Y     = 24'sd128000;
	localparam logic [REST_W-1:0]       RST_RESTITUTION = 17'd52429;
	localparam logic [RAD_W-1:0]        RST_RADIUS      = 20'd2560;
	localparam logic signed [POS_W-1:0] RST_START_X     = 21'sd115200;
	localparam logic signed [POS_W-1:0] RST_START_Y     = 21'sd76800;
	localparam logic signed [VEL_W-1:0] RST_START_VX    = 24'sd51200;
	localparam logic signed [VEL_W-1:0] RST_START_VY    = -24'sd25600;

	localparam logic REQ_STEP    = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	typedef struct packed {
		logic signed [ACC_W-1:0] accel_x;
		logic signed [ACC_W-1:0] accel_y;
		logic [REST_W-1:0]       restitution;
		logic [RAD_W-1:0]        radius;
		logic signed [POS_W-1:0] start_x;
		logic signed [POS_W-1:0] start_y;
		logic signed [VEL_W-1:0] start_vx;
		logic signed [VEL_W-1:0] start_vy;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VADD,
		ST_PMUL,
		ST_PADD,
		ST_CHK,
		ST_BMUL,
		ST_BUPD,
		ST_WB,
		ST_OUT
	} st_t;

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
		logic signed [VEL_W-1:0] r;
		if (v[SUM_W-1:VEL_W-1] == '0 || v[SUM_W-1:VEL_W-1] == '1) begin
			r = v[VEL_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(VEL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VEL_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
			r = v[POS_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/bps_regs.sv
// bps_regs.sv: configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module bps_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bps_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output bps_pkg::cfg_t                     cfg
);

	bps_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_x     <= bps_pkg::RST_ACCEL_X;
			cfg_q.accel_y     <= bps_pkg::RST_ACCEL_Y;
			cfg_q.restitution <= bps_pkg::RST_RESTITUTION;
			cfg_q.radius      <= bps_pkg::RST_RADIUS;
			cfg_q.start_x     <= bps_pkg::RST_START_X;
			cfg_q.start_y     <= bps_pkg::RST_START_Y;
			cfg_q.start_vx    <= bps_pkg::RST_START_VX;
			cfg_q.start_vy    <= bps_pkg::RST_START_VY;
		end else if (wr_en) begin
			unique case (idx)
				bps_pkg::REG_ACCEL_X:     cfg_q.accel_x     <= pwdata[bps_pkg::ACC_W-1:0];
				bps_pkg::REG_ACCEL_Y:     cfg_q.accel_y     <= pwdata[bps_pkg::ACC_W-1:0];
				bps_pkg::REG_RESTITUTION: cfg_q.restitution <= pwdata[bps_pkg::REST_W-1:0];
				bps_pkg::REG_RADIUS:      cfg_q.radius      <= pwdata[bps_pkg::RAD_W-1:0];
				bps_pkg::REG_START_X:     cfg_q.start_x     <= pwdata[bps_pkg::POS_W-1:0];
				bps_pkg::REG_START_Y:     cfg_q.start_y     <= pwdata[bps_pkg::POS_W-1:0];
				bps_pkg::REG_START_VX:    cfg_q.start_vx    <= pwdata[bps_pkg::VEL_W-1:0];
				bps_pkg::REG_START_VY:    cfg_q.start_vy    <= pwdata[bps_pkg::VEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bps_pkg::REG_ACCEL_X:     prdata = 32'({cfg_q.accel_x});
			bps_pkg::REG_ACCEL_Y:     prdata = 32'({cfg_q.accel_y});
			bps_pkg::REG_RESTITUTION: prdata = 32'(cfg_q.restitution);
			bps_pkg::REG_RADIUS:      prdata = 32'(cfg_q.radius);
			bps_pkg::REG_START_X:     prdata = 32'({cfg_q.start_x});
			bps_pkg::REG_START_Y:     prdata = 32'({cfg_q.start_y});
			bps_pkg::REG_START_VX:    prdata = 32'({cfg_q.start_vx});
			bps_pkg::REG_START_VY:    prdata = 32'({cfg_q.start_vy});
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/bouncing_particle_step.sv
// bouncing_particle_step.sv: top level, sequencer and shared multiplier datapath
`timescale 1ns / 1ps
`default_nettype none

// Advances one particle in a box per accepted transaction. For a step transaction,
// each axis runs through a velocity multiply and add, a position multiply and add,
// a wall check, up to two restitution multiplies and a write-back, all on one shared
// 25 x 18 bit multiplier whose product is registered before use, followed by loading
// the output register. A restart transaction goes straight to loading the output
// register. The input side stalls while a transaction is in progress; the result
// sits in an output register, so the next transaction may be accepted while a result
// waits to be taken. Configuration registers are only to be written while the block is idle.
module bouncing_particle_step (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [bps_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              req_type,
	input  wire logic [bps_pkg::DT_W-1:0]          dt,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [bps_pkg::POS_W-1:0]       out_x,
	output logic signed [bps_pkg::POS_W-1:0]       out_y,
	output logic signed [bps_pkg::VEL_W-1:0]       out_vx,
	output logic signed [bps_pkg::VEL_W-1:0]       out_vy,
	output logic [bps_pkg::HIT_W-1:0]              hit_walls
);

	bps_pkg::cfg_t cfg;
	bps_pkg::st_t  state_q, state_d;

	logic signed [bps_pkg::POS_W-1:0] cur_x_q, cur_y_q;
	logic signed [bps_pkg::VEL_W-1:0] cur_vx_q, cur_vy_q;
	logic signed [bps_pkg::POS_W-1:0] p_q;
	logic signed [bps_pkg::VEL_W-1:0] v_q;
	logic signed [bps_pkg::SHP_W-1:0] sh_q;
	logic [bps_pkg::DT_W-1:0]         dt_q;
	logic [bps_pkg::HIT_W-1:0]        hit_q;
	logic [1:0]                       bcnt_q;
	logic                             ax_q;
	logic                             out_valid_q;

	logic                             accept;
	logic                             out_load;
	logic signed [24:0]               mul_a;
	logic [bps_pkg::REST_W-1:0]       mul_b;
	logic signed [42:0]               prod;
	logic signed [bps_pkg::POS_W-1:0] pos_axis;
	logic signed [bps_pkg::VEL_W-1:0] vel_axis;
	logic signed [bps_pkg::ACC_W-1:0] acc_axis;
	logic signed [bps_pkg::CHK_W-1:0] size_axis;
	logic signed [bps_pkg::CHK_W-1:0] p_ext, rad_ext;
	logic                             lo_hit, hi_hit;
	logic signed [bps_pkg::POS_W-1:0] np;
	logic [1:0]                       bcnt_d;

	bps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == bps_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	assign pos_axis  = ax_q ? cur_y_q : cur_x_q;
	assign vel_axis  = ax_q ? cur_vy_q : cur_vx_q;
	assign acc_axis  = ax_q ? cfg.accel_y : cfg.accel_x;
	assign size_axis = ax_q ? bps_pkg::SIZE_Y : bps_pkg::SIZE_X;

	// wall check on the unclamped position
	assign p_ext   = bps_pkg::CHK_W'(p_q);
	assign rad_ext = $signed({3'b000, cfg.radius});
	assign lo_hit  = p_ext < rad_ext;
	assign hi_hit  = (p_ext + rad_ext) > size_axis;
	assign bcnt_d  = {1'b0, lo_hit} + {1'b0, hi_hit};

	always_comb begin
		if (hi_hit) begin
			np = bps_pkg::sat_pos(bps_pkg::SUM_W'(size_axis - rad_ext));
		end else if (lo_hit) begin
			np = $signed({1'b0, cfg.radius});
		end else begin
			np = p_q;
		end
	end

	// shared multiplier operand selection
	always_comb begin
		unique case (state_q)
			bps_pkg::ST_VMUL: begin
				mul_a = 25'(acc_axis);
				mul_b = {1'b0, dt_q};
			end
			bps_pkg::ST_PMUL: begin
				mul_a = 25'(v_q);
				mul_b = {1'b0, dt_q};
			end
			bps_pkg::ST_BMUL: begin
				mul_a = -(25'(v_q));
				mul_b = cfg.restitution;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * $signed({1'b0, mul_b});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bps_pkg::ST_IDLE: begin
				if (accept) state_d = req_type ? bps_pkg::ST_OUT : bps_pkg::ST_VMUL;
			end
			bps_pkg::ST_VMUL: state_d = bps_pkg::ST_VADD;
			bps_pkg::ST_VADD: state_d = bps_pkg::ST_PMUL;
			bps_pkg::ST_PMUL: state_d = bps_pkg::ST_PADD;
			bps_pkg::ST_PADD: state_d = bps_pkg::ST_CHK;
			bps_pkg::ST_CHK:  state_d = (bcnt_d != 2'd0) ? bps_pkg::ST_BMUL : bps_pkg::ST_WB;
			bps_pkg::ST_BMUL: state_d = bps_pkg::ST_BUPD;
			bps_pkg::ST_BUPD: state_d = (bcnt_q == 2'd1) ? bps_pkg::ST_WB : bps_pkg::ST_BMUL;
			bps_pkg::ST_WB:   state_d = ax_q ? bps_pkg::ST_OUT : bps_pkg::ST_VMUL;
			bps_pkg::ST_OUT:  if (out_load) state_d = bps_pkg::ST_IDLE;
			default:          state_d = bps_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != bps_pkg::ST_IDLE);
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cur_x_q     <= bps_pkg::RST_START_X;
			cur_y_q     <= bps_pkg::RST_START_Y;
			cur_vx_q    <= bps_pkg::RST_START_VX;
			cur_vy_q    <= bps_pkg::RST_START_VY;
			ax_q        <= 1'b0;
			bcnt_q      <= 2'd0;
			hit_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bps_pkg::ST_IDLE: begin
					if (accept) begin
						ax_q  <= 1'b0;
						hit_q <= '0;
						if (req_type == bps_pkg::REQ_RESTART) begin
							cur_x_q  <= cfg.start_x;
							cur_y_q  <= cfg.start_y;
							cur_vx_q <= cfg.start_vx;
							cur_vy_q <= cfg.start_vy;
						end
					end
				end
				bps_pkg::ST_CHK: begin
					bcnt_q <= bcnt_d;
					if (lo_hit) hit_q[{ax_q, 1'b0}] <= 1'b1;
					if (hi_hit) hit_q[{ax_q, 1'b1}] <= 1'b1;
				end
				bps_pkg::ST_BUPD: bcnt_q <= bcnt_q - 2'd1;
				bps_pkg::ST_WB: begin
					if (ax_q) begin
						cur_y_q  <= p_q;
						cur_vy_q <= v_q;
					end else begin
						cur_x_q  <= p_q;
						cur_vx_q <= v_q;
					end
					ax_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (accept) dt_q <= dt;
		// product >> 16, the dropped bits give floor rounding
		if (state_q == bps_pkg::ST_VMUL || state_q == bps_pkg::ST_PMUL ||
		    state_q == bps_pkg::ST_BMUL) begin
			sh_q <= prod[42:16];
		end
		case (state_q)
			bps_pkg::ST_VADD: v_q <= bps_pkg::sat_vel(bps_pkg::SUM_W'(vel_axis)
			                                          + bps_pkg::SUM_W'(sh_q));
			bps_pkg::ST_PADD: p_q <= bps_pkg::sat_pos(bps_pkg::SUM_W'(pos_axis)
			                                          + bps_pkg::SUM_W'(sh_q));
			bps_pkg::ST_CHK:  p_q <= np;
			bps_pkg::ST_BUPD: v_q <= bps_pkg::sat_vel(bps_pkg::SUM_W'(sh_q));
			default: ;
		endcase
		if (out_load) begin
			out_x     <= cur_x_q;
			out_y     <= cur_y_q;
			out_vx    <= cur_vx_q;
			out_vy    <= cur_vy_q;
			hit_walls <= hit_q;
		end
	end

	a_restart_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type) |=> (state_q == bps_pkg::ST_OUT))
		else $error("restart did not go straight to the result");

	a_step_starts_x: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !req_type) |=> (state_q == bps_pkg::ST_VMUL && !ax_q))
		else $error("step did not start on the horizontal axis");

	a_bounce_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bps_pkg::ST_BMUL) |-> (bcnt_q != 2'd0 && bcnt_q != 2'd3))
		else $error("bounce multiply with no hit pending");

	a_out_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bps_pkg::ST_OUT) |-> (ax_q || hit_q == '0))
		else $error("restart result carries wall hits");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bps_pkg::ST_IDLE) |-> in_stall)
		else $error("input open while a transaction is in progress");

endmodule

`default_nettype wire
